### src/dgsr_pkg.sv
// Shared types and constants for the select-line game pad reader.
package dgsr_pkg;

    localparam int WAIT_W = 16;
    localparam int PINS_W = 6;
    localparam int BTN_W  = 12;
    localparam int NUM_SAMPLES = 5;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd20;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_DETECT = 2'd1,
        ACT_POLL   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_THREE  = 2'd1,
        KIND_SIX    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_A     = 4'd1,
        PH_B     = 4'd2,
        PH_LOW3  = 4'd3,
        PH_D     = 4'd4,
        PH_LOW5  = 4'd5,
        PH_E     = 4'd6,
        PH_C     = 4'd7,
        PH_END   = 4'd8
    } phase_t;

    // Masks applied to the pin samples.
    localparam logic [PINS_W-1:0] DIR_MASK   = 6'h0f;
    localparam logic [PINS_W-1:0] DIR_MIDDLE = 6'h03;
    localparam logic [PINS_W-1:0] BIT_START  = 6'h20;
    localparam logic [PINS_W-1:0] BIT_BA     = 6'h10;

    typedef struct packed {
        logic              select_level;
        logic              aux_level;
        logic              busy_res;
        logic              report_valid;
        logic [BTN_W-1:0]  buttons;
        logic              pad_kind;
        logic [1:0]        controller_kind;
        logic              changed;
    } res_t;

endpackage

### src/db9_gamepad_select_reader_top.sv
// Top level of the select-line game pad reader: input stage, sequencer and result stage.
//
// Each input transfer carries one tick: an action code (tick, start detection,
// start poll) and the six active-low pin levels seen on that tick. Every input
// transfer yields exactly one result transfer carrying the select and aux line
// levels, the busy flag, and on the tick a poll completes report_valid with
// the twelve button flags, the pad kind and a changed flag.
// The item is held in an input register, processed by the sequencer in one
// pass, and its result is captured in an output register before it is
// offered. One item is accepted per clock cycle while the receiver keeps
// taking results; the sequencer state is updated once per item, which sets
// that rate.
// When the receiver stalls, the result and the item behind it are held and
// in_ready drops; nothing is lost and processing resumes as soon as out_ready
// returns.
// Reset clears both stages, puts the sequencer in idle with a three-button pad
// assumed, and sets wait_ticks to 20. The user must write wait_ticks through cfg_wr_en
// and cfg_wr_data only while the block is idle (not enforced here); zero counts as one.
module db9_gamepad_select_reader_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dgsr_pkg::WAIT_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [dgsr_pkg::PINS_W-1:0]   pins,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          select_level,
    output logic                          aux_level,
    output logic                          busy_res,
    output logic                          report_valid,
    output logic [dgsr_pkg::BTN_W-1:0]    buttons,
    output logic                          pad_kind,
    output logic [1:0]                    controller_kind,
    output logic                          changed
);
    import dgsr_pkg::*;

    logic [WAIT_W-1:0]  wait_ticks_reg;
    logic               item_valid_reg;
    logic [1:0]         action_reg;
    logic [PINS_W-1:0]  pins_reg;
    logic               res_valid_reg;
    res_t               res_reg;
    res_t               step_res;
    logic               advance;
    logic               fire;

    assign advance  = !res_valid_reg || out_ready;
    assign fire     = item_valid_reg && advance;
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg <= WAIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            wait_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            pins_reg   <= pins;
        end
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    dgsr_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .action     (action_reg),
        .pins       (pins_reg),
        .wait_ticks (wait_ticks_reg),
        .res        (step_res)
    );

    assign out_valid       = res_valid_reg;
    assign select_level    = res_reg.select_level;
    assign aux_level       = res_reg.aux_level;
    assign busy_res        = res_reg.busy_res;
    assign report_valid    = res_reg.report_valid;
    assign buttons         = res_reg.buttons;
    assign pad_kind        = res_reg.pad_kind;
    assign controller_kind = res_reg.controller_kind;
    assign changed         = res_reg.changed;

endmodule

### src/dgsr_step.sv
// Sequencer state, pad classification and button mapping for one tick.
module dgsr_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [1:0]                    action,
    input  logic [dgsr_pkg::PINS_W-1:0]   pins,
    input  logic [dgsr_pkg::WAIT_W-1:0]   wait_ticks,
    output dgsr_pkg::res_t                res
);
    import dgsr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [WAIT_W-1:0]   wait_count_reg, wait_count_next;
    logic                detecting_reg, detecting_next;
    kind_t               detected_kind_reg, detected_kind_next;
    logic [BTN_W-1:0]    reported_buttons_reg, reported_buttons_next;
    logic                reported_kind_reg, reported_kind_next;
    logic [PINS_W-1:0]   samples_reg [NUM_SAMPLES];
    logic [PINS_W-1:0]   samples_next [NUM_SAMPLES];

    logic [WAIT_W-1:0]   wait_load;
    logic [WAIT_W-1:0]   wait_dec;
    logic                expired;
    logic                finished;
    logic                report;
    logic                chg;
    logic [BTN_W-1:0]    btn_map;
    logic                kind_map;
    kind_t               kind_class;
    logic [PINS_W-1:0]   d0, d1, d2;

    assign wait_load = (wait_ticks == '0) ? WAIT_W'(1) : wait_ticks;
    assign wait_dec  = wait_count_reg - WAIT_W'(1);
    assign expired   = (wait_dec == '0);

    // Next state of the sequencer.
    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        detecting_next  = detecting_reg;
        finished        = 1'b0;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            samples_next[i] = samples_reg[i];
        end
        if (phase_reg == PH_IDLE)
        begin
            if (action == ACT_DETECT)
            begin
                detecting_next  = 1'b1;
                phase_next      = PH_A;
                wait_count_next = wait_load;
            end
            else if (action == ACT_POLL)
            begin
                detecting_next  = 1'b0;
                phase_next      = PH_A;
                wait_count_next = wait_load;
            end
        end
        else
        begin
            wait_count_next = wait_dec;
            if (expired)
            begin
                wait_count_next = wait_load;
                unique case (phase_reg)
                    PH_A:
                    begin
                        samples_next[0] = pins;
                        // A single-read pad needs only the first sample.
                        if (!detecting_reg && detected_kind_reg == KIND_SINGLE)
                        begin
                            phase_next      = PH_IDLE;
                            wait_count_next = wait_dec;
                            finished        = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_B;
                        end
                    end
                    PH_B:
                    begin
                        samples_next[1] = pins;
                        phase_next      = PH_LOW3;
                    end
                    PH_LOW3: phase_next = PH_D;
                    PH_D:
                    begin
                        samples_next[3] = pins;
                        phase_next      = PH_LOW5;
                    end
                    PH_LOW5: phase_next = PH_E;
                    PH_E:
                    begin
                        samples_next[4] = pins;
                        phase_next      = PH_C;
                    end
                    PH_C:
                    begin
                        samples_next[2] = pins;
                        phase_next      = PH_END;
                    end
                    default:
                    begin
                        phase_next      = PH_IDLE;
                        wait_count_next = wait_dec;
                        finished        = 1'b1;
                    end
                endcase
            end
        end
        // A finished detection goes straight on to a poll.
        if (finished && detecting_reg)
        begin
            detecting_next  = 1'b0;
            phase_next      = PH_A;
            wait_count_next = wait_load;
        end
    end

    // Classification and button mapping at the end of a sequence.
    always_comb
    begin
        kind_class = KIND_SINGLE;
        if ((samples_reg[0] & DIR_MASK) == DIR_MASK
            && (samples_reg[1] & DIR_MASK) == DIR_MIDDLE)
        begin
            if ((samples_reg[3] & DIR_MASK) != DIR_MIDDLE
                || (samples_reg[4] & DIR_MASK) != DIR_MIDDLE)
            begin
                kind_class = KIND_SIX;
            end
            else
            begin
                kind_class = KIND_THREE;
            end
        end
        if ((samples_reg[1] & BIT_START) == '0)
        begin
            kind_class = KIND_SIX;
        end

        // The first sample may be taken on this very tick.
        d0 = ~samples_next[0];
        d1 = ~samples_reg[1];
        d2 = ~samples_reg[2];
        btn_map = '0;
        btn_map[3:0] = d0[3:0];
        if (detected_kind_reg != KIND_SINGLE)
        begin
            kind_map   = 1'b1;
            btn_map[4] = d1[4];
            btn_map[5] = d0[4];
            btn_map[6] = d0[5];
            btn_map[7] = d1[5];
            if (detected_kind_reg == KIND_SIX)
            begin
                btn_map[8]  = d2[2];
                btn_map[9]  = d2[1];
                btn_map[10] = d2[0];
                btn_map[11] = d2[3];
            end
        end
        else
        begin
            kind_map   = 1'b0;
            btn_map[5] = d0[4];
            btn_map[6] = d0[5];
        end

        detected_kind_next    = detected_kind_reg;
        reported_buttons_next = reported_buttons_reg;
        reported_kind_next    = reported_kind_reg;
        report                = 1'b0;
        chg                   = 1'b0;
        if (finished)
        begin
            if (detecting_reg)
            begin
                detected_kind_next = kind_class;
            end
            else
            begin
                report = 1'b1;
                chg    = (btn_map != reported_buttons_reg)
                         || (kind_map != reported_kind_reg);
                reported_buttons_next = btn_map;
                reported_kind_next    = kind_map;
            end
        end
    end

    // Result of this tick, taken from the state it leaves behind.
    always_comb
    begin
        res.select_level    = !(phase_next == PH_B || phase_next == PH_D
                                || phase_next == PH_E || phase_next == PH_END);
        res.aux_level       = (phase_next == PH_A);
        res.busy_res        = (phase_next != PH_IDLE);
        res.report_valid    = report;
        res.buttons         = reported_buttons_next;
        res.pad_kind        = reported_kind_next;
        res.controller_kind = detected_kind_next;
        res.changed         = chg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            wait_count_reg       <= '0;
            detecting_reg        <= 1'b0;
            detected_kind_reg    <= KIND_THREE;
            reported_buttons_reg <= '0;
            reported_kind_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg            <= phase_next;
            wait_count_reg       <= wait_count_next;
            detecting_reg        <= detecting_next;
            detected_kind_reg    <= detected_kind_next;
            reported_buttons_reg <= reported_buttons_next;
            reported_kind_reg    <= reported_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
            begin
                samples_reg[i] <= samples_next[i];
            end
        end
    end

endmodule
